>>> sv/cfbs_pkg.sv
// ----------------------------------------------------------------------------
// cfbs_pkg: shared constants for the CAN frame bit serializer
// Word size, CRC-15 polynomial, stuffing run length and frame field sizes.
// ----------------------------------------------------------------------------
package cfbs_pkg;

	localparam int WORD_BITS = 32;
	localparam int WORD_IDX_W = $clog2(WORD_BITS);
	localparam int COUNT_W = 6;

	localparam int ID_W = 29;
	localparam int DLC_W = 4;
	localparam int DATA_W = 64;

	localparam int CRC_W = 15;
	localparam logic [CRC_W-1:0] CRC_POLY = 15'h4599;
	localparam logic [CRC_W-1:0] CRC_MASK = 15'h7FFF;

	localparam int STUFF_RUN = 5;
	localparam int RUN_W = 3;

	// SOF + ext id + SRR + IDE + RTR + r1 + r0 + DLC + 64 data bits
	localparam int RAW_BITS = 103;
	localparam int RAW_CNT_W = 7;
	localparam int HDR_EXT_BITS = 39;
	localparam int HDR_STD_BITS = 19;
	localparam int MAX_BYTES = 8;

	// CRC delimiter, ACK slot, 11 recessive bits
	localparam int TAIL_RECESSIVE = 11;
	localparam int TAIL_BITS = TAIL_RECESSIVE + 2;
	localparam int TAIL_CNT_W = 4;

endpackage

>>> sv/can_frame_bit_serializer_top.sv
// a frame leaves its first word once 32 bus bits are built and its last word in the
// cycle after its final bus bit; one bus bit (data or stuff) is produced per cycle
// while the output is not stalled; the stuffed frame length is up to 160 bits, and the next
// frame is accepted only after the final bus bit of the last one, by the single serial path
// reset: arst_n clears the sequencer and the output valid, and no frame is in flight
// ----------------------------------------------------------------------------
// can_frame_bit_serializer_top: CAN 2.0 frame transmit serializer
// Builds the stuffed bus bit stream of one frame bit by bit and packs it
// into 32-bit output words.
// ----------------------------------------------------------------------------
module can_frame_bit_serializer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cfbs_pkg::ID_W-1:0]           identifier,
	input  logic                                extended,
	input  logic                                remote,
	input  logic [cfbs_pkg::DLC_W-1:0]          dlc,
	input  logic [cfbs_pkg::DATA_W-1:0]         data_bytes,
	input  logic                                ack_recessive,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cfbs_pkg::WORD_BITS-1:0]      frame_bits,
	output logic [cfbs_pkg::COUNT_W-1:0]        bit_count,
	output logic                                last_word
);
	import cfbs_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RAW,
		PH_CRC,
		PH_TAIL
	} phase_t;

	phase_t                  ph_q;
	logic [RAW_BITS-1:0]     raw_q;
	logic [RAW_CNT_W-1:0]    raw_cnt_q;
	logic [CRC_W-1:0]        crc_q;
	logic [TAIL_CNT_W-1:0]   crc_cnt_q;
	logic [TAIL_BITS-1:0]    tail_q;
	logic [TAIL_CNT_W-1:0]   tail_cnt_q;
	logic [RUN_W-1:0]        run_q;
	logic                    lvl_q;
	logic [WORD_BITS-1:0]    asm_q;
	logic [WORD_IDX_W-1:0]   asm_cnt_q;
	logic                    out_valid_q;
	logic [WORD_BITS-1:0]    frame_bits_q;
	logic [COUNT_W-1:0]      bit_count_q;
	logic                    last_word_q;

	logic [DATA_W-1:0]       dseq;
	logic [RAW_BITS-1:0]     raw_load;
	logic [RAW_CNT_W-1:0]    raw_len;
	logic [3:0]              nbytes;
	logic                    stuff;
	logic                    dbit;
	logic                    tx_bit;
	logic                    fin;
	logic                    word_full;
	logic                    step;
	logic                    accept;
	logic [WORD_BITS-1:0]    asm_next;
	logic [CRC_W-1:0]        crc_next;

	// byte 0 first, each byte msb first
	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			dseq[DATA_W-1-8*i -: 8] = data_bytes[8*i +: 8];
		end
	end

	always_comb begin
		if (extended) begin
			raw_load = {1'b0, identifier[28:18], 2'b11, identifier[17:0], remote, 2'b00,
				dlc, dseq};
		end else begin
			raw_load = {1'b0, identifier[10:0], remote, 2'b00, dlc, dseq,
				{(RAW_BITS-HDR_STD_BITS-DATA_W){1'b1}}};
		end
		if (remote) begin
			nbytes = 4'd0;
		end else if (dlc > DLC_W'(MAX_BYTES)) begin
			nbytes = 4'(MAX_BYTES);
		end else begin
			nbytes = dlc;
		end
		raw_len = (extended ? RAW_CNT_W'(HDR_EXT_BITS) : RAW_CNT_W'(HDR_STD_BITS))
			+ {nbytes, 3'b000};
	end

	always_comb begin
		stuff = (run_q == RUN_W'(STUFF_RUN));
		case (ph_q)
			PH_RAW:  dbit = raw_q[RAW_BITS-1];
			PH_CRC:  dbit = crc_q[CRC_W-1];
			PH_TAIL: dbit = tail_q[TAIL_BITS-1];
			default: dbit = 1'b1;
		endcase
		tx_bit = stuff ? ~lvl_q : dbit;
		fin = (ph_q == PH_TAIL) && !stuff && (tail_cnt_q == TAIL_CNT_W'(TAIL_BITS-1));
		word_full = (asm_cnt_q == WORD_IDX_W'(WORD_BITS-1));
		asm_next = asm_q;
		asm_next[asm_cnt_q] = tx_bit;
		crc_next = {crc_q[CRC_W-2:0], 1'b0} & CRC_MASK;
		if (crc_q[CRC_W-1] ^ dbit) begin
			crc_next = crc_next ^ CRC_POLY;
		end
		accept = in_valid && in_ready;
		step = (ph_q != PH_IDLE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			out_valid_q <= 1'b0;
			run_q <= RUN_W'(1);
			lvl_q <= 1'b1;
			asm_cnt_q <= '0;
			raw_cnt_q <= '0;
			crc_cnt_q <= '0;
			tail_cnt_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				ph_q <= PH_RAW;
				raw_q <= raw_load;
				raw_cnt_q <= raw_len;
				crc_q <= '0;
				tail_q <= {1'b1, ack_recessive, {TAIL_RECESSIVE{1'b1}}};
				tail_cnt_q <= '0;
				crc_cnt_q <= '0;
				run_q <= RUN_W'(1);
				lvl_q <= 1'b1;
				asm_q <= '1;
				asm_cnt_q <= '0;
			end else if (step) begin
				if (word_full || fin) begin
					out_valid_q <= 1'b1;
					frame_bits_q <= asm_next;
					bit_count_q <= COUNT_W'(asm_cnt_q) + COUNT_W'(1);
					last_word_q <= fin;
					asm_q <= '1;
					asm_cnt_q <= '0;
				end else begin
					asm_q <= asm_next;
					asm_cnt_q <= asm_cnt_q + WORD_IDX_W'(1);
				end
				if (stuff) begin
					lvl_q <= ~lvl_q;
					run_q <= RUN_W'(1);
				end else begin
					if (ph_q != PH_TAIL) begin
						if (dbit == lvl_q) begin
							run_q <= run_q + RUN_W'(1);
						end else begin
							lvl_q <= dbit;
							run_q <= RUN_W'(1);
						end
					end
					case (ph_q)
						PH_RAW: begin
							crc_q <= crc_next;
							raw_q <= {raw_q[RAW_BITS-2:0], 1'b1};
							raw_cnt_q <= raw_cnt_q - RAW_CNT_W'(1);
							if (raw_cnt_q == RAW_CNT_W'(1)) begin
								ph_q <= PH_CRC;
							end
						end
						PH_CRC: begin
							crc_q <= {crc_q[CRC_W-2:0], 1'b1};
							crc_cnt_q <= crc_cnt_q + TAIL_CNT_W'(1);
							if (crc_cnt_q == TAIL_CNT_W'(CRC_W-1)) begin
								ph_q <= PH_TAIL;
							end
						end
						PH_TAIL: begin
							tail_q <= {tail_q[TAIL_BITS-2:0], 1'b1};
							tail_cnt_q <= tail_cnt_q + TAIL_CNT_W'(1);
							if (fin) begin
								ph_q <= PH_IDLE;
							end
						end
						default: begin
							ph_q <= PH_IDLE;
						end
					endcase
				end
			end
		end
	end

	assign in_ready = (ph_q == PH_IDLE);
	assign out_valid = out_valid_q;
	assign frame_bits = frame_bits_q;
	assign bit_count = bit_count_q;
	assign last_word = last_word_q;

	// stuffing run length stays within one to five
	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q >= RUN_W'(1) && run_q <= RUN_W'(STUFF_RUN))
		else $error("stuff run counter out of range");

	// no partial word is left over between frames
	a_idle_asm: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_IDLE |-> asm_cnt_q == '0)
		else $error("partial word left while idle");

	// a word beat always carries at least one bit
	a_count_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> bit_count_q != '0)
		else $error("empty output word");

	// the tail is never stuffed: entering it clears any pending stuff bit first
	a_tail_run: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_TAIL && tail_cnt_q != '0 |-> run_q != RUN_W'(STUFF_RUN))
		else $error("stuff pending inside frame tail");

endmodule

>>> bench/can_frame_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_check_pkg: bus word scoreboard for the CAN frame serializer bench
// Rebuilds the stuffed bus bit stream of each accepted frame descriptor,
// packs it into output words and checks the words that the block returns.
// ----------------------------------------------------------------------------
package can_frame_check_pkg;

	import cfbs_pkg::*;

	typedef struct packed {
		logic [WORD_BITS-1:0] bits;
		logic [COUNT_W-1:0]   count;
		logic                 last;
	} bus_word_t;

	class can_word_scoreboard;
		bus_word_t        words_due[$];
		int unsigned      mismatches;
		int unsigned      frames_noted;
		int unsigned      words_checked;

		// frame under construction
		bit               levels[$];
		logic [CRC_W-1:0] crc;
		bit               run_level;
		int               run_len;

		function new();
			mismatches = 0;
			frames_noted = 0;
			words_checked = 0;
		endfunction

		// one bit through crc and bit stuffing
		function void put_stuffed(bit b);
			bit fb;
			fb = crc[CRC_W-1] ^ b;
			crc = {crc[CRC_W-2:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
			levels.push_back(b);
			if (b == run_level) begin
				run_len++;
				if (run_len == STUFF_RUN) begin
					// stuff bit opens the next run
					run_level = !run_level;
					levels.push_back(run_level);
					run_len = 1;
				end
			end else begin
				run_level = b;
				run_len = 1;
			end
		endfunction

		function void put_field(logic [63:0] v, int hi, int lo);
			for (int i = hi; i >= lo; i--) begin
				put_stuffed(v[i]);
			end
		endfunction

		function void note_frame(logic [ID_W-1:0] id, logic ext, logic rem,
				logic [DLC_W-1:0] dlc, logic [DATA_W-1:0] data, logic ack);
			int               nbytes;
			int               nwords;
			int               base;
			int               cnt;
			bus_word_t        w;
			logic [CRC_W-1:0] crc_sent;
			levels.delete();
			crc = '0;
			run_level = 1'b1;
			run_len = 1;
			put_stuffed(1'b0);
			if (ext) begin
				put_field(64'(id), 28, 18);
				put_stuffed(1'b1);
				put_stuffed(1'b1);
				put_field(64'(id), 17, 0);
			end else begin
				put_field(64'(id), 10, 0);
			end
			put_stuffed(rem);
			put_stuffed(1'b0);
			put_stuffed(1'b0);
			put_field(64'(dlc), 3, 0);
			if (!rem) begin
				nbytes = (dlc > MAX_BYTES) ? MAX_BYTES : int'(dlc);
				for (int i = 0; i < nbytes; i++) begin
					put_field(64'(data[8*i +: 8]), 7, 0);
				end
			end
			crc_sent = crc;
			put_field(64'(crc_sent), CRC_W-1, 0);
			// crc delimiter, ack slot, then the unstuffed recessive tail
			levels.push_back(1'b1);
			levels.push_back(ack);
			repeat (TAIL_RECESSIVE) levels.push_back(1'b1);
			nwords = (levels.size() + WORD_BITS - 1) / WORD_BITS;
			for (int k = 0; k < nwords; k++) begin
				base = k * WORD_BITS;
				cnt = levels.size() - base;
				if (cnt > WORD_BITS) begin
					cnt = WORD_BITS;
				end
				w.bits = '1;
				for (int t = 0; t < cnt; t++) begin
					if (!levels[base + t]) begin
						w.bits[t] = 1'b0;
					end
				end
				w.count = COUNT_W'(cnt);
				w.last = (k == nwords - 1);
				words_due.push_back(w);
			end
			frames_noted++;
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40) begin
				$display("[%0t] mismatch: %s", $time, what);
			end
		endtask

		task check_word(logic [WORD_BITS-1:0] bits, logic [COUNT_W-1:0] count, logic last);
			bus_word_t due;
			words_checked++;
			if (words_due.size() == 0) begin
				report($sformatf("word with none due: bits=%h count=%0d last=%b",
					bits, count, last));
			end else begin
				due = words_due.pop_front();
				if (bits !== due.bits) begin
					report($sformatf("frame_bits %h, due %h", bits, due.bits));
				end
				if (count !== due.count) begin
					report($sformatf("bit_count %0d, due %0d", count, due.count));
				end
				if (last !== due.last) begin
					report($sformatf("last_word %b, due %b", last, due.last));
				end
			end
		endtask
	endclass

endpackage

>>> bench/tb_can_frame_bit_serializer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_frame_bit_serializer_top: bench for the CAN frame bit serializer
// Sends directed and random frame descriptors in bursts, takes output words
// under a shifting stall pattern and checks every word against a rebuilt
// bus bit stream.
// ----------------------------------------------------------------------------
module tb_can_frame_bit_serializer_top;

	import cfbs_pkg::*;
	import can_frame_check_pkg::*;

	localparam int RANDOM_FRAMES = 410;
	localparam int IDLE_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [ID_W-1:0]      identifier = '0;
	logic                 extended = 1'b0;
	logic                 remote = 1'b0;
	logic [DLC_W-1:0]     dlc = '0;
	logic [DATA_W-1:0]    data_bytes = '0;
	logic                 ack_recessive = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [WORD_BITS-1:0] frame_bits;
	logic [COUNT_W-1:0]   bit_count;
	logic                 last_word;

	can_word_scoreboard   sb;
	int                   burst_left = 0;
	int unsigned          ext_frames = 0;
	int unsigned          remote_frames = 0;
	int unsigned          rx_cycle = 0;
	int unsigned          rx_hold = 0;
	int unsigned          idle_cycles = 0;

	can_frame_bit_serializer_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.identifier    (identifier),
		.extended      (extended),
		.remote        (remote),
		.dlc           (dlc),
		.data_bytes    (data_bytes),
		.ack_recessive (ack_recessive),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_bits    (frame_bits),
		.bit_count     (bit_count),
		.last_word     (last_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver stall pattern, stepping through four modes in turn
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cycle <= 0;
			rx_hold <= 0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			case (rx_cycle[10:9])
				2'd0: begin
					out_ready <= 1'b1;
				end
				2'd1: begin
					out_ready <= ($urandom_range(0, 99) < 70);
				end
				2'd2: begin
					out_ready <= (rx_cycle % 3 == 0);
				end
				default: begin
					// long stalls now and then
					if (rx_hold != 0) begin
						rx_hold <= rx_hold - 1;
						out_ready <= 1'b0;
					end else if ($urandom_range(0, 15) == 0) begin
						rx_hold <= $urandom_range(5, 40);
						out_ready <= 1'b0;
					end else begin
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_word(frame_bits, bit_count, last_word);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles == IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// bursts of random length, random gaps between them
	task automatic pace_sender();
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(20, 200)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
	endtask

	task automatic send_frame(input logic [ID_W-1:0] id, input logic ext, input logic rem,
			input logic [DLC_W-1:0] len, input logic [DATA_W-1:0] data, input logic ack);
		identifier <= id;
		extended <= ext;
		remote <= rem;
		dlc <= len;
		data_bytes <= data;
		ack_recessive <= ack;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_frame(id, ext, rem, len, data, ack);
		ext_frames += ext;
		remote_frames += rem;
	endtask

	// bit pattern made of random runs, so stuffing fires often
	function automatic logic [63:0] runny_bits();
		logic [63:0] v;
		bit          lvl;
		int          pos;
		int          len;
		v = '0;
		lvl = $urandom_range(0, 1);
		pos = 0;
		while (pos < 64) begin
			len = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
			for (int i = 0; i < len && pos < 64; i++) begin
				v[pos] = lvl;
				pos++;
			end
			lvl = !lvl;
		end
		return v;
	endfunction

	initial begin
		logic [ID_W-1:0]   id;
		logic              ext;
		logic              rem;
		logic [DLC_W-1:0]  len;
		logic [DATA_W-1:0] data;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes: all dominant, all recessive, long dlc, remote, ignored fields
		pace_sender();
		send_frame('0, 1'b0, 1'b0, 4'd0, '0, 1'b0);
		pace_sender();
		send_frame(29'h7FF, 1'b0, 1'b0, 4'd8, '1, 1'b1);
		pace_sender();
		send_frame('1, 1'b1, 1'b0, 4'd8, '0, 1'b0);
		pace_sender();
		send_frame('0, 1'b1, 1'b1, 4'd15, '1, 1'b1);
		pace_sender();
		send_frame(29'h2AA, 1'b0, 1'b1, 4'd8, 64'h0123_4567_89AB_CDEF, 1'b0);
		pace_sender();
		send_frame(29'h1FFF_F800 | 29'h555, 1'b0, 1'b0, 4'd2, 64'hFFFF, 1'b1);
		pace_sender();
		send_frame(29'h0AAA_AAAA, 1'b1, 1'b0, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		pace_sender();
		send_frame(29'h1555_5555, 1'b1, 1'b0, 4'd8, 64'h5555_5555_5555_5555, 1'b1);
		pace_sender();
		send_frame('1, 1'b1, 1'b0, 4'd15, '1, 1'b1);
		pace_sender();
		send_frame(29'h123, 1'b0, 1'b0, 4'd9, 64'hF0F0_0F0F_8000_0001, 1'b0);
		pace_sender();
		send_frame(29'h000_07C0, 1'b1, 1'b1, 4'd0, '0, 1'b0);
		pace_sender();
		send_frame('1, 1'b0, 1'b1, 4'd15, '0, 1'b1);
		for (int i = 1; i <= 7; i++) begin
			pace_sender();
			send_frame(29'(i * 29'h0123_4567), i[0], 1'b0, DLC_W'(i),
				{$urandom, $urandom}, i[1]);
		end

		for (int n = 0; n < RANDOM_FRAMES; n++) begin
			ext = $urandom_range(0, 1);
			rem = ($urandom_range(0, 3) == 0);
			len = ($urandom_range(0, 2) == 0) ? 4'd8 : DLC_W'($urandom_range(0, 15));
			id = ($urandom_range(0, 1) == 0) ? ID_W'(runny_bits()) : ID_W'($urandom);
			data = ($urandom_range(0, 1) == 0) ? runny_bits() : {$urandom, $urandom};
			pace_sender();
			send_frame(id, ext, rem, len, data, 1'($urandom_range(0, 1)));
		end
		in_valid <= 1'b0;

		while (sb.words_due.size() != 0) @(posedge clk);
		// room for any stray word after the last one due
		repeat (200) @(posedge clk);

		$display("frames sent: %0d (%0d extended, %0d remote), words checked: %0d",
			sb.frames_noted, ext_frames, remote_frames, sb.words_checked);
		$display("covered dlc 0..15, stuffing-heavy fields, bursty input and output stalls");
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
